// ===== src/scl_pkg.sv =====
// Package for the subpicture command locator: packet limit, result classes
// and the command byte decoder. No dependencies.
package scl_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 4096;
    localparam logic [15:0] MaxPacketBytes   = 16'(MAX_PACKET_BYTES);

    // Header layout: two big-endian 16-bit words
    localparam logic [15:0] HDR_SIZE_HI   = 16'd0;
    localparam logic [15:0] HDR_SIZE_LO   = 16'd1;
    localparam logic [15:0] HDR_OFFSET_HI = 16'd2;
    localparam logic [15:0] HDR_OFFSET_LO = 16'd3;
    localparam logic [15:0] HDR_BYTES     = 16'd4;

    // Command byte codes
    localparam logic [7:0] CMD_FORCED_DISPLAY = 8'h00;
    localparam logic [7:0] CMD_DISPLAY_START  = 8'h01;
    localparam logic [7:0] CMD_DISPLAY_STOP   = 8'h02;

    typedef enum logic [2:0] {
        CLS_FORCED_DISPLAY = 3'd0,
        CLS_DISPLAY_START  = 3'd1,
        CLS_DISPLAY_STOP   = 3'd2,
        CLS_NO_COMMAND     = 3'd3,
        CLS_OTHER          = 3'd4
    } t_cmd_class;

    function automatic t_cmd_class classify(input logic [7:0] cmd);
        t_cmd_class cls;
        unique case (cmd)
            CMD_FORCED_DISPLAY: cls = CLS_FORCED_DISPLAY;
            CMD_DISPLAY_START:  cls = CLS_DISPLAY_START;
            CMD_DISPLAY_STOP:   cls = CLS_DISPLAY_STOP;
            default:            cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

// ===== src/subpicture_command_locator.sv =====
// Subpicture command locator: parses subpicture packet bytes and classifies
// the first control command of each unit. Depends on scl_pkg.
//
// Usage:
//   Input channel: one packet byte per word on i_data_byte, with
//   i_last_in_packet high on the final byte of each packet. A word is taken
//   on a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: one word on o_command_class for every accepted byte that
//   is marked last, taken on an edge with o_out_valid high and i_out_stall low.
//   Classes: forced display, display start, display stop, no command in this
//   packet, or another command.
//   Output timing: when the output slot is free or being taken, the class of a
//   packet appears on o_out_valid in the cycle after its last byte is accepted.
//   Throughput: one byte per cycle while o_in_stall is low; all parsing for a byte is
//   done in the cycle it is accepted, and the parser state is ready for the
//   next byte at the following edge.
//   Reset (i_rst_n low, synchronous): clears the parser state and empties
//   both result slots; the next byte is taken as the start of a packet.
//   Receiver stall: the pending result holds on the output port; one more
//   result is caught in a skid slot, and only while that slot is full does
//   o_in_stall rise. Bytes that are not last keep flowing until then.
module subpicture_command_locator
    import scl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_in_packet,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_command_class
);

    // Parser state
    logic [15:0] r_cmd_offset,  n_cmd_offset;
    logic [15:0] r_unit_size,   n_unit_size;
    logic [15:0] r_bytes_rcvd,  n_bytes_rcvd;
    logic        r_cmd_next,    n_cmd_next;
    logic        r_skip,        n_skip;
    logic [15:0] r_byte_index,  n_byte_index;
    logic        r_header_mode, n_header_mode;
    logic [7:0]  r_pending_hi,  n_pending_hi;
    logic [7:0]  r_cmd_byte,    n_cmd_byte;
    logic        r_cmd_valid,   n_cmd_valid;

    // Result slots
    logic       r_out_valid,  n_out_valid;
    t_cmd_class r_out_class,  n_out_class;
    logic       r_skid_valid, n_skid_valid;
    t_cmd_class r_skid_class, n_skid_class;

    logic       in_accept;
    logic       out_take;
    logic       res_valid;
    t_cmd_class res_class;

    // Working values for the byte being taken
    logic        first_byte;
    logic        hdr;
    logic        in_range;
    logic [16:0] target;
    logic [15:0] size;
    logic [15:0] span;
    logic [16:0] sum;
    logic [15:0] br_sat;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign res_valid = in_accept && i_last_in_packet;

    always_comb begin
        n_cmd_offset  = r_cmd_offset;
        n_unit_size   = r_unit_size;
        n_bytes_rcvd  = r_bytes_rcvd;
        n_cmd_next    = r_cmd_next;
        n_skip        = r_skip;
        n_byte_index  = r_byte_index;
        n_header_mode = r_header_mode;
        n_pending_hi  = r_pending_hi;
        n_cmd_byte    = r_cmd_byte;
        n_cmd_valid   = r_cmd_valid;
        res_class     = CLS_NO_COMMAND;

        // Decide header mode and drop the old capture at the start of a packet
        first_byte = (r_byte_index == 16'd0);
        hdr        = first_byte ? (!r_skip && r_cmd_offset == 16'd0 && !r_cmd_next)
                                : r_header_mode;
        if (first_byte) begin
            n_cmd_valid = 1'b0;
        end

        in_range = (r_byte_index < MaxPacketBytes);
        target   = hdr ? ({1'b0, r_cmd_offset} + 17'(HDR_BYTES)) : {1'b0, r_cmd_offset};

        if (in_accept) begin
            if (in_range) begin
                if (!r_skip) begin
                    if (hdr && r_byte_index < HDR_BYTES) begin
                        unique case (r_byte_index[1:0])
                            HDR_SIZE_HI[1:0]:   n_pending_hi = i_data_byte;
                            HDR_SIZE_LO[1:0]:   n_unit_size  = {r_pending_hi, i_data_byte};
                            HDR_OFFSET_HI[1:0]: n_pending_hi = i_data_byte;
                            HDR_OFFSET_LO[1:0]: n_cmd_offset = {r_pending_hi, i_data_byte};
                            default:            n_pending_hi = r_pending_hi;
                        endcase
                    end else if ({1'b0, r_byte_index} == target && !n_cmd_valid) begin
                        n_cmd_byte  = i_data_byte;
                        n_cmd_valid = 1'b1;
                    end
                end
                n_byte_index = r_byte_index + 16'd1;
            end
            n_header_mode = hdr;
        end

        // Packet end: settle the offset and report
        size   = n_byte_index;
        sum    = {1'b0, r_bytes_rcvd} + {1'b0, size};
        br_sat = sum[16] ? 16'hFFFF : sum[15:0];
        span   = (hdr && size >= HDR_BYTES) ? (size - HDR_BYTES) : size;

        if (res_valid) begin
            if (r_skip) begin
                n_skip       = 1'b0;
                n_bytes_rcvd = 16'd0;
            end else begin
                n_bytes_rcvd = hdr ? size : br_sat;
                if (!(hdr && size < HDR_BYTES)) begin
                    if (n_cmd_offset > span) begin
                        n_cmd_offset = n_cmd_offset - span;
                    end else if (n_cmd_offset == span) begin
                        n_cmd_next   = 1'b1;
                        n_cmd_offset = 16'd0;
                    end else begin
                        if (n_bytes_rcvd < n_unit_size) begin
                            n_skip = 1'b1;
                        end
                        res_class    = classify(n_cmd_valid ? n_cmd_byte : CMD_FORCED_DISPLAY);
                        n_cmd_offset = 16'd0;
                        n_cmd_next   = 1'b0;
                    end
                end
            end
            n_byte_index  = 16'd0;
            n_header_mode = 1'b0;
            n_cmd_valid   = 1'b0;
        end else if (!in_accept) begin
            n_cmd_valid = r_cmd_valid;
        end
    end

    // Output register with one skid slot behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_class  = r_out_class;
        n_skid_valid = r_skid_valid;
        n_skid_class = r_skid_class;
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_class  = r_skid_class;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out_class = res_class;
            end
        end else if (res_valid) begin
            n_skid_valid = 1'b1;
            n_skid_class = res_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_offset  <= '0;
            r_unit_size   <= '0;
            r_bytes_rcvd  <= '0;
            r_cmd_next    <= 1'b0;
            r_skip        <= 1'b0;
            r_byte_index  <= '0;
            r_header_mode <= 1'b0;
            r_pending_hi  <= '0;
            r_cmd_byte    <= '0;
            r_cmd_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_skid_valid  <= 1'b0;
        end else begin
            r_cmd_offset  <= n_cmd_offset;
            r_unit_size   <= n_unit_size;
            r_bytes_rcvd  <= n_bytes_rcvd;
            r_cmd_next    <= n_cmd_next;
            r_skip        <= n_skip;
            r_byte_index  <= n_byte_index;
            r_header_mode <= n_header_mode;
            r_pending_hi  <= n_pending_hi;
            r_cmd_byte    <= n_cmd_byte;
            r_cmd_valid   <= n_cmd_valid;
            r_out_valid   <= n_out_valid;
            r_skid_valid  <= n_skid_valid;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_class  <= n_out_class;
        r_skid_class <= n_skid_class;
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_command_class = r_out_class;

`ifndef SYNTHESIS
    // Skid slot fills only behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot full while output empty");

    // A stalled result is never dropped
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_class))
        else $error("stalled result lost");

    // Packet byte count never passes the limit
    a_index_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= MaxPacketBytes)
        else $error("byte index beyond packet limit");

    // Last byte restarts the packet and always yields a result
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_last_in_packet |=> r_byte_index == 16'd0 && r_out_valid)
        else $error("packet end not handled");

    // Skipping and a command at the next start exclude each other
    a_skip_vs_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_skip && r_cmd_next))
        else $error("skip and command-at-next-start both set");
`endif

endmodule

// ===== verif/tb_subpicture_command_locator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for subpicture_command_locator: a directed table, then random
// subpicture units and one closing plain unit. Depends on scl_pkg.
module tb_subpicture_command_locator;
    import scl_pkg::*;

    localparam int unsigned CLK_HALF_NS   = 4;
    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned DRAIN_LIMIT   = 5000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned HOLD_TRIGGER  = 30;
    localparam int unsigned RUN_LIMIT_NS  = 8_000_000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_TOGGLE,
        STALL_HEAVY
    } t_stall_mode;

    // One word of the directed table. fixed marks a last byte whose class is typed in here.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        t_cmd_class cls;
    } t_stim_row;

    localparam int unsigned DIRECTED_ROWS = 27;
    localparam t_stim_row DIRECTED_STIMULUS [DIRECTED_ROWS] = '{
        // short header straight after reset: size word only, no command
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h10, 1'b1, 1'b1, CLS_NO_COMMAND},
        // header with the command right behind it, unit not yet complete
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h08, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b1, 1'b1, CLS_FORCED_DISPLAY},
        // the data packet that follows is skipped whole
        '{8'hAA, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h55, 1'b1, 1'b1, CLS_NO_COMMAND},
        // complete unit in one packet: display start
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h06, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h01, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'hFF, 1'b1, 1'b1, CLS_DISPLAY_START},
        // complete unit: display stop
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h05, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h02, 1'b1, 1'b1, CLS_DISPLAY_STOP},
        // command byte lands on byte 0 of the next packet
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h20, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h00, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h02, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h80, 1'b0, 1'b0, CLS_NO_COMMAND},
        '{8'h7F, 1'b1, 1'b0, CLS_NO_COMMAND},
        '{8'h7E, 1'b1, 1'b0, CLS_NO_COMMAND}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic       i_last_in_packet;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_command_class;

    // Sideband travelling with each driven word: a class typed into the directed table.
    logic       drv_fixed;
    t_cmd_class drv_fixed_cls;

    // Predictor state: a private copy of the parser
    logic [15:0] p_offset;
    logic [15:0] p_unit_size;
    logic [15:0] p_received;
    logic [15:0] p_index;
    logic [7:0]  p_pending;
    logic [7:0]  p_cmd;
    bit          p_at_next;
    bit          p_skip;
    bit          p_header;
    bit          p_captured;

    t_cmd_class  expected_class_q [$];
    int unsigned parsed_count;
    int unsigned results_seen;
    int unsigned fail_count;
    int unsigned burst_left;

    subpicture_command_locator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_last_in_packet (i_last_in_packet),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_command_class  (o_command_class)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Hard stop in case the handshake locks up
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Advance the predictor by one accepted byte; produced is set on the last byte of a packet.
    task automatic predict_packet_byte(input logic [7:0] data, input bit is_last,
                                       output bit produced, output t_cmd_class cls);
        logic [16:0] target;
        logic [16:0] total;
        logic [15:0] span;
        logic [7:0]  cmd;
        bit          usable;
        produced = is_last;
        cls      = CLS_NO_COMMAND;
        // A packet opens with a unit header only when nothing is pending from the last one
        if (p_index == 16'd0) begin
            p_header   = !p_skip && p_offset == 16'd0 && !p_at_next;
            p_captured = 1'b0;
        end
        // Drop bytes past the packet limit: neither parsed nor counted
        if (p_index < MaxPacketBytes) begin
            if (!p_skip) begin
                if (p_header && p_index < HDR_BYTES) begin
                    case (p_index)
                        HDR_SIZE_HI, HDR_OFFSET_HI: p_pending   = data;
                        HDR_SIZE_LO:                p_unit_size = {p_pending, data};
                        default:                    p_offset    = {p_pending, data};
                    endcase
                end else begin
                    // The offset counts from just after the header
                    target = p_header ? {1'b0, p_offset} + {1'b0, HDR_BYTES}
                                      : {1'b0, p_offset};
                    if ({1'b0, p_index} == target && !p_captured) begin
                        p_cmd      = data;
                        p_captured = 1'b1;
                    end
                end
            end
            p_index++;
        end
        if (is_last) begin
            total      = {1'b0, p_received} + {1'b0, p_index};
            p_received = total[16] ? 16'hFFFF : total[15:0];
            if (p_skip) begin
                p_skip     = 1'b0;
                p_received = 16'd0;
            end else begin
                usable = 1'b1;
                span   = p_index;
                if (p_header) begin
                    // A header cut short leaves the offset alone and yields the no-command class
                    p_received = p_index;
                    if (p_index < HDR_BYTES)
                        usable = 1'b0;
                    else
                        span = p_index - HDR_BYTES;
                end
                if (usable) begin
                    if (p_offset > span) begin
                        p_offset = p_offset - span;
                    end else if (p_offset == span) begin
                        p_at_next = 1'b1;
                        p_offset  = 16'd0;
                    end else begin
                        // Command found before the unit is complete: the next packet is data only
                        if (p_received < p_unit_size)
                            p_skip = 1'b1;
                        // Nothing taken at the command position reads as a zero byte
                        cmd = p_captured ? p_cmd : CMD_FORCED_DISPLAY;
                        case (cmd)
                            CMD_FORCED_DISPLAY: cls = CLS_FORCED_DISPLAY;
                            CMD_DISPLAY_START:  cls = CLS_DISPLAY_START;
                            CMD_DISPLAY_STOP:   cls = CLS_DISPLAY_STOP;
                            default:            cls = CLS_OTHER;
                        endcase
                        p_offset  = 16'd0;
                        p_at_next = 1'b0;
                    end
                end
            end
            p_index    = 16'd0;
            p_header   = 1'b0;
            p_captured = 1'b0;
        end
    endtask

    // Offer one word and hold it until it is taken. Bursts of random length with idle gaps.
    task automatic send_byte(input logic [7:0] data, input bit is_last,
                             input bit fixed, input t_cmd_class fixed_cls);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_last_in_packet <= is_last;
        drv_fixed        <= fixed;
        drv_fixed_cls    <= fixed_cls;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
    endtask

    // Bring the parser back to a unit boundary: feed filler packets until the next packet
    // would be read as a header. The predictor is settled by the falling edge.
    task automatic finish_open_unit();
        int unsigned len;
        int unsigned i;
        forever begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            if (p_offset == 16'd0 && !p_at_next && !p_skip)
                break;
            len = (p_offset >= MaxPacketBytes) ? MAX_PACKET_BYTES : int'(p_offset) + 1;
            for (i = 0; i < len; i++)
                send_byte(8'($urandom), i == len - 1, 1'b0, CLS_NO_COMMAND);
        end
    endtask

    // Sample both handshakes at the rising edge: predict on every taken input word, check on
    // every taken result word against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        bit         produced;
        t_cmd_class predicted;
        t_cmd_class wanted;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                if (!p_skip)
                    parsed_count++;
                predict_packet_byte(i_data_byte, i_last_in_packet, produced, predicted);
                if (produced)
                    expected_class_q.push_back(drv_fixed ? drv_fixed_cls : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_class_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected class %0d", o_command_class));
                end else begin
                    wanted = expected_class_q.pop_front();
                    if (o_command_class !== 3'(wanted))
                        report_mismatch($sformatf("command_class %0d, expected %0d (%s)",
                                                  o_command_class, wanted, wanted.name()));
                end
            end
        end
    end

    // Receiver: stall on a changing pattern of its own, plus one long hold-off once a few
    // dozen results have come, so the skid slot fills and the input stalls.
    initial begin : receiver
        int unsigned hold_left;
        int unsigned mode_left;
        t_stall_mode mode;
        bit          toggle;
        bit          long_done;
        hold_left   = 0;
        mode_left   = 0;
        mode        = STALL_NONE;
        toggle      = 1'b0;
        long_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!long_done && results_seen >= HOLD_TRIGGER) begin
                long_done   = 1'b1;
                hold_left   = LONG_HOLD;
                i_out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                toggle = !toggle;
                case (mode)
                    STALL_NONE:   i_out_stall <= 1'b0;
                    STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_TOGGLE: i_out_stall <= toggle;
                    default:      i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [7:0]  unit_bytes [0:127];
        logic [7:0]  b;
        t_stim_row   row;
        int unsigned usize;
        int unsigned uoff;
        int unsigned cpos;
        int unsigned pos;
        int unsigned plen;
        int unsigned kind;
        int unsigned drain;
        int unsigned i;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_data_byte      = 8'h00;
        i_last_in_packet = 1'b0;
        drv_fixed        = 1'b0;
        drv_fixed_cls    = CLS_NO_COMMAND;
        parsed_count     = 0;
        results_seen     = 0;
        fail_count       = 0;
        burst_left       = 0;
        // Predictor comes out of reset with everything cleared
        p_offset    = 16'd0;
        p_unit_size = 16'd0;
        p_received  = 16'd0;
        p_index     = 16'd0;
        p_pending   = 8'h00;
        p_cmd       = 8'h00;
        p_at_next   = 1'b0;
        p_skip      = 1'b0;
        p_header    = 1'b0;
        p_captured  = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED_STIMULUS[i];
            send_byte(row.data, row.last, row.fixed, row.cls);
        end

        // Random units: mostly well-formed with random content, some short headers and noise
        while (parsed_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
            finish_open_unit();
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                // Noise packet read as a header; keep its offset small so it drains cheaply
                plen = $urandom_range(1, 12);
                for (i = 0; i < plen; i++) begin
                    b = 8'($urandom);
                    if (i == 2)
                        b = 8'h00;
                    else if (i == 3)
                        b = 8'($urandom_range(0, 15));
                    send_byte(b, i == plen - 1, 1'b0, CLS_NO_COMMAND);
                end
            end else begin
                // Broken sequence: a header packet cut short ahead of the real unit
                if (kind < 5) begin
                    plen = $urandom_range(1, 3);
                    for (i = 0; i < plen; i++)
                        send_byte(8'($urandom), i == plen - 1, 1'b0, CLS_NO_COMMAND);
                end
                usize = $urandom_range(5, 90);
                uoff  = $urandom_range(0, usize - 5);
                cpos  = uoff + 4;
                for (i = 0; i < usize; i++)
                    unit_bytes[i] = 8'($urandom);
                unit_bytes[0] = usize[15:8];
                unit_bytes[1] = usize[7:0];
                unit_bytes[2] = uoff[15:8];
                unit_bytes[3] = uoff[7:0];
                case ($urandom_range(0, 3))
                    0:       unit_bytes[cpos] = CMD_FORCED_DISPLAY;
                    1:       unit_bytes[cpos] = CMD_DISPLAY_START;
                    2:       unit_bytes[cpos] = CMD_DISPLAY_STOP;
                    default: ;
                endcase
                // Split into packets; whatever follows the command packet goes as one packet
                pos = 0;
                while (pos < usize) begin
                    if (pos > cpos) begin
                        plen = usize - pos;
                    end else begin
                        plen = $urandom_range(pos == 0 ? 4 : 1, 24);
                        // Now and then end the packet just short of the command byte
                        if (cpos > pos && cpos - pos <= 24 && $urandom_range(0, 5) == 0)
                            plen = cpos - pos;
                        if (plen > usize - pos)
                            plen = usize - pos;
                    end
                    for (i = 0; i < plen; i++)
                        send_byte(unit_bytes[pos + i], i == plen - 1, 1'b0, CLS_NO_COMMAND);
                    pos += plen;
                end
            end
        end

        // A plain unit at a unit boundary must be read as a header
        finish_open_unit();
        for (i = 0; i < 5; i++) begin
            b = (i == 1) ? 8'h05 : (i == 4) ? CMD_DISPLAY_START : 8'h00;
            send_byte(b, i == 4, 1'b0, CLS_NO_COMMAND);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain: wait for every expected word, then a few cycles for any stray one
        drain = 0;
        while (expected_class_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_class_q.size() != 0)
            report_mismatch($sformatf("%0d expected classes never arrived",
                                      expected_class_q.size()));

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/scl_pkg.sv
src/subpicture_command_locator.sv
verif/tb_subpicture_command_locator.sv
